// ----- rtl/sfrc_pkg.sv -----
`timescale 1ns / 1ps

package sfrc_pkg;

    localparam int STORE_DEPTH_DEF = 192;

    // configuration port
    localparam int CFG_W     = 1;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEVICE_KIND = 1'b0,
        REG_USE_CRC     = 1'b1
    } cfg_reg_t;

    // ASCII framing characters
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // binary headers: (lead >= 192, 103) and (176, 164)
    localparam logic [7:0] BIN_LEAD_MIN  = 8'd192;
    localparam logic [7:0] BIN_LEN_SHORT = 8'd103;
    localparam logic [7:0] BIN_LEAD_LONG = 8'd176;
    localparam logic [7:0] BIN_LEN_LONG  = 8'd164;

    // a 103-byte binary frame sums only bytes 0..99
    localparam int BIN_SUM_CUT_LEN = 103;

    localparam int ASCII_MIN_LEN = 6;
    localparam int BIN_MIN_LEN   = 2;

    localparam logic [15:0] CRC_INIT = 16'h554D;
    // four 0x30 digit offsets weighted 4096, 256, 16, 1, modulo 2^16
    localparam logic [15:0] DIGIT_BIAS = 16'h3330;

    typedef struct packed {
        logic       stored;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       frame_start;
        logic [7:0] header_byte;
        logic       frame_done;
        logic [7:0] frame_length;
        logic       nak;
        logic       crc_bad;
        logic       waiting;
    } result_t;

    // reflected CRC-16 (0x8408), one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0]  p;
        logic [15:0] q;
        p = crc[7:0] ^ data;
        p = p ^ (p << 4);
        q = {p, 8'h00} ^ {5'b0, p, 3'b0} ^ {12'b0, p[7:4]};
        crc_fold = {8'h00, crc[15:8]} ^ q;
    endfunction

    // four offset digits as one 16-bit value
    function automatic logic [15:0] digit_value(input logic [7:0] d3, input logic [7:0] d2,
                                                input logic [7:0] d1, input logic [7:0] d0);
        digit_value = {d3[3:0], 12'b0} + {d2, 8'b0} + {4'b0, d1, 4'b0} + {8'b0, d0} - DIGIT_BIAS;
    endfunction

endpackage

// ----- rtl/serial_frame_receiver_with_check.sv -----
`timescale 1ns / 1ps

// Serial frame receiver with frame check.
// Input channel (s_*): one word per received byte (s_action 0) or an arm
// command (s_action 1). Arm clears the write pointer, NAK and check flags
// and sets waiting. Result channel (m_*): exactly one word per input word,
// telling whether the byte was stored and where, whether it opened or closed
// a frame, and the NAK / check-error / waiting flags after that word.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 device_kind, 1 use_crc) in the same cycle; write only while idle.
// The result is registered and shows on m_* in the cycle after the
// input word is taken. Throughput: one word per cycle while m_ready is high.
// The binary sum folds the byte two places behind the write pointer, the
// running ASCII sum and CRC the byte five behind, read ahead from the frame
// store's read port into a register, so the check at frame end stalls nothing.
// Reset clears the flags, the pointer and the framing state; device_kind
// resets to 0 and use_crc to 1. The frame store needs no clearing.
// When the result is not taken (m_ready low) it holds and s_ready drops
// until it is taken.
module serial_frame_receiver_with_check #(
    parameter int STORE_DEPTH = sfrc_pkg::STORE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sfrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfrc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_stored,
    output logic [7:0]                     m_store_index,
    output logic [7:0]                     m_store_byte,
    output logic                           m_frame_start,
    output logic [7:0]                     m_header_byte,
    output logic                           m_frame_done,
    output logic [7:0]                     m_frame_length,
    output logic                           m_nak,
    output logic                           m_crc_bad,
    output logic                           m_waiting
);
    import sfrc_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int PTR_W = $clog2(STORE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(STORE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_BIN_FOLD = PTR_W'(2);
    localparam logic [PTR_W-1:0] PTR_ASC_FOLD = PTR_W'(6);
    localparam logic [PTR_W-1:0] PTR_BYTE3 = PTR_W'(3);
    localparam logic [PTR_W-1:0] PTR_LAG   = PTR_W'(5);
    localparam logic [PTR_W-1:0] PTR_CUT   = PTR_W'(BIN_SUM_CUT_LEN);
    localparam logic [PTR_W-1:0] PTR_ASC_MIN = PTR_W'(ASCII_MIN_LEN);
    localparam logic [PTR_W-1:0] PTR_BIN_MIN = PTR_W'(BIN_MIN_LEN);

    // configuration
    logic device_kind_reg;
    logic use_crc_reg;

    // framing state
    logic [7:0]       prev_reg, prev_next;
    logic             capturing_reg, capturing_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [7:0]       exp_len_reg, exp_len_next;
    logic [7:0]       byte3_reg, byte3_next;
    logic             waiting_reg, waiting_next;
    logic             nak_reg, nak_next;
    logic             bad_reg, bad_next;

    // running check: tail_reg[k] holds the byte at wp - 1 - k
    logic [7:0]  tail_reg [0:3];
    logic [7:0]  tail_next [0:3];
    logic [15:0] bin_acc_reg, bin_acc_next;
    logic [15:0] asum_reg, asum_next;
    logic [15:0] crc_reg, crc_next;

    // frame store
    logic [7:0]       store_mem [STORE_DEPTH];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [PTR_W-1:0] lag_ptr;
    logic [7:0]       mem_rd_reg;

    // output register
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;

    // per-word working values
    logic             accept;
    logic             header;
    logic             start;
    logic             cap_a;
    logic             store;
    logic             frame_end;
    logic             check_fail;
    logic [PTR_W-1:0] wp_a;
    logic [PTR_W-1:0] wp_b;
    logic [7:0]       ta [0:3];
    logic [7:0]       pt [0:4];
    logic [7:0]       byte3_a;
    logic [15:0]      bin_a, asum_a, crc_a;
    logic [15:0]      bin_sum;
    logic [15:0]      asc_acc;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        prev_next      = prev_reg;
        capturing_next = capturing_reg;
        wp_next        = wp_reg;
        exp_len_next   = exp_len_reg;
        byte3_next     = byte3_reg;
        waiting_next   = waiting_reg;
        nak_next       = nak_reg;
        bad_next       = bad_reg;
        bin_acc_next   = bin_acc_reg;
        asum_next      = asum_reg;
        crc_next       = crc_reg;
        for (int k = 0; k < 4; k++) begin
            tail_next[k] = tail_reg[k];
            ta[k]        = tail_reg[k];
        end
        for (int k = 0; k < 5; k++) begin
            pt[k] = 8'h00;
        end
        res        = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        header     = 1'b0;
        start      = 1'b0;
        cap_a      = capturing_reg;
        store      = 1'b0;
        frame_end  = 1'b0;
        check_fail = 1'b0;
        wp_a       = wp_reg;
        wp_b       = wp_reg;
        byte3_a    = byte3_reg;
        bin_a      = bin_acc_reg;
        asum_a     = asum_reg;
        crc_a      = crc_reg;
        bin_sum    = 16'h0000;
        asc_acc    = 16'h0000;

        if (accept && s_action) begin
            waiting_next = 1'b1;
            wp_next      = '0;
            bad_next     = 1'b0;
            nak_next     = 1'b0;
            // a frame still being captured restarts its stored sequence at index 0
            bin_acc_next = 16'h0000;
            asum_next    = 16'h0000;
            crc_next     = CRC_INIT;
        end else if (accept) begin
            if (device_kind_reg) begin
                if ((prev_reg >= BIN_LEAD_MIN && s_rx_byte == BIN_LEN_SHORT) ||
                    (prev_reg == BIN_LEAD_LONG && s_rx_byte == BIN_LEN_LONG)) begin
                    header       = 1'b1;
                    exp_len_next = s_rx_byte;
                end
            end else if (wp_reg == '0 && s_rx_byte > CH_SPACE && prev_reg == CH_STX) begin
                header = 1'b1;
            end

            start = header && !capturing_reg;
            cap_a = capturing_reg || start;
            if (start) begin
                wp_a    = PTR_ONE;
                byte3_a = 8'h00;
                bin_a   = 16'h0000;
                asum_a  = 16'h0000;
                crc_a   = CRC_INIT;
                ta[0]   = prev_reg;
            end

            store = cap_a && (wp_a < PTR_DEPTH);
            if (store) begin
                mem_we    = 1'b1;
                mem_waddr = wp_a[IDX_W-1:0];
                if (wp_a >= PTR_BIN_FOLD) begin
                    bin_a = bin_a + {8'h00, ta[1]};
                end
                // fold the byte five places behind, read from the store
                if (wp_a >= PTR_ASC_FOLD) begin
                    asum_a = asum_a + {8'h00, mem_rd_reg};
                    crc_a  = crc_fold(crc_a, mem_rd_reg);
                end
                if (wp_a == PTR_BYTE3) begin
                    byte3_a = s_rx_byte;
                end
                pt[0] = s_rx_byte;
                pt[1] = ta[0];
                pt[2] = ta[1];
                pt[3] = ta[2];
                pt[4] = ta[3];
                wp_b  = wp_a + PTR_ONE;
            end else begin
                pt[0] = ta[0];
                pt[1] = ta[1];
                pt[2] = ta[2];
                pt[3] = ta[3];
                pt[4] = mem_rd_reg;
                wp_b  = wp_a;
            end

            for (int k = 0; k < 4; k++) begin
                tail_next[k] = pt[k];
            end
            wp_next      = wp_b;
            byte3_next   = byte3_a;
            bin_acc_next = bin_a;
            asum_next    = asum_a;
            crc_next     = crc_a;

            // check as seen after this byte: pt[k] is the byte at wp_b - 1 - k
            if (device_kind_reg) begin
                bin_sum    = (wp_b == PTR_CUT) ? bin_a - {8'h00, pt[2]} : bin_a;
                check_fail = (wp_b < PTR_BIN_MIN) || (bin_sum != {pt[0], pt[1]});
            end else begin
                asc_acc    = use_crc_reg ? crc_a : asum_a;
                check_fail = (wp_b < PTR_ASC_MIN) ||
                             (asc_acc != digit_value(pt[4], pt[3], pt[2], pt[1]));
            end

            if (cap_a) begin
                frame_end = device_kind_reg ? (wp_b >= PTR_W'(exp_len_next))
                                            : (s_rx_byte == CH_ETX);
            end

            res.stored      = store;
            res.store_index = store ? wp_a[7:0] : 8'h00;
            res.store_byte  = store ? s_rx_byte : 8'h00;
            res.frame_start = start;
            res.header_byte = start ? prev_reg : 8'h00;

            if (frame_end) begin
                capturing_next = 1'b0;
                prev_next      = 8'h00;
                if (!device_kind_reg && byte3_a == CH_NAK) begin
                    nak_next = 1'b1;
                end
                bad_next         = check_fail;
                waiting_next     = 1'b0;
                res.frame_done   = 1'b1;
                res.frame_length = wp_b[7:0];
            end else begin
                capturing_next = cap_a;
                prev_next      = s_rx_byte;
            end
        end

        res.nak     = nak_next;
        res.crc_bad = bad_next;
        res.waiting = waiting_next;
    end

    // prefetch the byte five places behind the pointer for the next word
    assign lag_ptr   = wp_next - PTR_LAG;
    assign mem_raddr = (wp_next >= PTR_LAG) ? lag_ptr[IDX_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= s_rx_byte;
        end
        mem_rd_reg <= store_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_kind_reg <= 1'b0;
            use_crc_reg     <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEVICE_KIND: device_kind_reg <= cfg_wdata[0];
                REG_USE_CRC:     use_crc_reg     <= cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= 8'h00;
            capturing_reg <= 1'b0;
            wp_reg        <= '0;
            exp_len_reg   <= 8'h00;
            byte3_reg     <= 8'h00;
            waiting_reg   <= 1'b0;
            nak_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            bin_acc_reg   <= 16'h0000;
            asum_reg      <= 16'h0000;
            crc_reg       <= CRC_INIT;
        end else begin
            prev_reg      <= prev_next;
            capturing_reg <= capturing_next;
            wp_reg        <= wp_next;
            exp_len_reg   <= exp_len_next;
            byte3_reg     <= byte3_next;
            waiting_reg   <= waiting_next;
            nak_reg       <= nak_next;
            bad_reg       <= bad_next;
            bin_acc_reg   <= bin_acc_next;
            asum_reg      <= asum_next;
            crc_reg       <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 4; k++) begin
            tail_reg[k] <= tail_next[k];
        end
    end

    // output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_stored       = out_reg.stored;
    assign m_store_index  = out_reg.store_index;
    assign m_store_byte   = out_reg.store_byte;
    assign m_frame_start  = out_reg.frame_start;
    assign m_header_byte  = out_reg.header_byte;
    assign m_frame_done   = out_reg.frame_done;
    assign m_frame_length = out_reg.frame_length;
    assign m_nak          = out_reg.nak;
    assign m_crc_bad      = out_reg.crc_bad;
    assign m_waiting      = out_reg.waiting;

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= PTR_DEPTH)
        else $error("write pointer past store depth");

    a_arm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_action |=> wp_reg == '0 && waiting_reg && !nak_reg && !bad_reg)
        else $error("arm did not reset pointer and flags");

    a_done_not_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> !m_waiting)
        else $error("frame end left waiting set");

    a_start_stores_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_start |-> m_stored && m_store_index == 8'd1)
        else $error("frame start did not store at index 1");

endmodule
